FILE: rtl/relr_pkg.sv
// Shared types, constants and helpers for the RELR relocation decoder.
package relr_pkg;

   localparam int unsigned WORD_W       = 64;
   localparam int unsigned MASK_W       = 63;
   localparam int unsigned IDX_W        = 6;
   localparam int unsigned BYTE_SHIFT_W = 3;
   localparam logic [WORD_W-1:0] WORD_STEP   = 64'd8;
   localparam logic [WORD_W-1:0] BITMAP_SPAN = 64'd504;

   localparam int unsigned CMD_DEPTH  = 2;
   localparam int unsigned CMD_PTR_W  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned CSR_IDX_BIT = 3;

   typedef enum logic {
      CSR_STAGING_BASE     = 1'b0,
      CSR_RELOCATION_DELTA = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] relr_word;
      logic              table_end;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] target_address;
      logic [WORD_W-1:0] add_value;
      logic              last_of_run;
   } rsp_type;

   // One run of targets: base offset plus a mask of word slots.
   typedef struct packed {
      logic [WORD_W-1:0] base;
      logic [MASK_W-1:0] mask;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic emit;
      logic last;
   } back_stat_type;

   // Index of the lowest set bit of a mask.
   function automatic logic [IDX_W-1:0] lowest_index(input logic [MASK_W-1:0] mask);
      logic [MASK_W-1:0] onehot;
      logic [IDX_W-1:0]  idx;
      onehot = mask & (~mask + {{(MASK_W-1){1'b0}}, 1'b1});
      idx    = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (onehot[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: rtl/relr_front.sv
// Front end: accepts RELR words, tracks the running offset, builds run commands.
module relr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  relr_pkg::req_type req_data,
   output logic              cmd_push,
   output relr_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);

   logic [relr_pkg::WORD_W-1:0] offset_ff;
   logic [relr_pkg::WORD_W-1:0] offset_in;
   logic                        accept;
   logic                        is_bitmap;

   always_comb begin
      accept    = req_push && !cmd_full;
      req_full  = cmd_full;
      is_bitmap = req_data.relr_word[0];

      // Address word is a run of one slot at the word itself.
      if (is_bitmap) begin
         cmd_data.base = offset_ff;
         cmd_data.mask = req_data.relr_word[relr_pkg::WORD_W-1:1];
      end else begin
         cmd_data.base = req_data.relr_word;
         cmd_data.mask = {{(relr_pkg::MASK_W-1){1'b0}}, 1'b1};
      end

      // Drop empty bitmaps: they only advance the offset.
      cmd_push = accept && (cmd_data.mask != '0);

      offset_in = offset_ff;
      if (accept) begin
         if (req_data.table_end) begin
            offset_in = '0;
         end else if (is_bitmap) begin
            offset_in = offset_ff + relr_pkg::BITMAP_SPAN;
         end else begin
            offset_in = req_data.relr_word + relr_pkg::WORD_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

FILE: rtl/relr_cmd_queue.sv
// Short command queue between the front end and the target generator.
module relr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  relr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output relr_pkg::cmd_type pop_data,
   output logic              empty
);

   relr_pkg::cmd_type                entries_ff [relr_pkg::CMD_DEPTH];
   logic [relr_pkg::CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [relr_pkg::CMD_PTR_W-1:0]   wr_ptr_in;
   logic [relr_pkg::CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [relr_pkg::CMD_PTR_W-1:0]   rd_ptr_in;
   logic [relr_pkg::CMD_CNT_W-1:0]   count_ff;
   logic [relr_pkg::CMD_CNT_W-1:0]   count_in;
   logic                             do_push;
   logic                             do_pop;

   localparam logic [relr_pkg::CMD_PTR_W-1:0] LAST_PTR =
      relr_pkg::CMD_PTR_W'(relr_pkg::CMD_DEPTH - 1);
   localparam logic [relr_pkg::CMD_CNT_W-1:0] DEPTH_CNT =
      relr_pkg::CMD_CNT_W'(relr_pkg::CMD_DEPTH);

   always_comb begin
      full     = (count_ff == DEPTH_CNT);
      empty    = (count_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/relr_back.sv
// Back end: walks a run's slot mask, emitting one patch target per cycle while results are taken.
module relr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_empty,
   input  relr_pkg::cmd_type           cmd_data,
   output logic                        cmd_pop,
   input  logic [relr_pkg::WORD_W-1:0] staging_base,
   input  logic [relr_pkg::WORD_W-1:0] relocation_delta,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output relr_pkg::rsp_type           rsp_data,
   output relr_pkg::back_stat_type     stat
);

   logic                        busy_ff;
   logic                        busy_in;
   logic [relr_pkg::WORD_W-1:0] base_sum_ff;
   logic [relr_pkg::WORD_W-1:0] base_sum_in;
   logic [relr_pkg::MASK_W-1:0] mask_ff;
   logic [relr_pkg::MASK_W-1:0] mask_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   relr_pkg::rsp_type           rsp_data_ff;
   relr_pkg::rsp_type           rsp_data_in;
   logic [relr_pkg::MASK_W-1:0] mask_rest;
   logic [relr_pkg::IDX_W-1:0]  slot;
   logic                        load;
   logic                        emit;
   logic                        last;

   always_comb begin
      load      = !busy_ff && !cmd_empty;
      cmd_pop   = load;
      emit      = busy_ff && (!rsp_valid_ff || rsp_pop);
      slot      = relr_pkg::lowest_index(mask_ff);
      mask_rest = mask_ff & (mask_ff - {{(relr_pkg::MASK_W-1){1'b0}}, 1'b1});
      last      = (mask_rest == '0);

      busy_in     = busy_ff;
      base_sum_in = base_sum_ff;
      mask_in     = mask_ff;
      if (load) begin
         busy_in     = 1'b1;
         base_sum_in = staging_base + cmd_data.base;
         mask_in     = cmd_data.mask;
      end else if (emit) begin
         busy_in = !last;
         mask_in = mask_rest;
      end

      // Hold the result until taken; refill in the same cycle it is popped.
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.target_address = base_sum_ff +
            {{(relr_pkg::WORD_W-relr_pkg::IDX_W-relr_pkg::BYTE_SHIFT_W){1'b0}},
             slot, {relr_pkg::BYTE_SHIFT_W{1'b0}}};
         rsp_data_in.add_value      = relocation_delta;
         rsp_data_in.last_of_run    = last;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end

      rsp_empty = !rsp_valid_ff;
      rsp_data  = rsp_data_ff;
      stat.busy = busy_ff;
      stat.emit = emit;
      stat.last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_sum_ff <= base_sum_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/relr_relocation_decoder_unit.sv
// Top level of the RELR relative-relocation decoder.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------
//  req_     | in        | req_push / req_full    | relr_word, table_end
//  rsp_     | out       | rsp_pop / rsp_empty    | target_address, add_value, last_of_run
//  csr_     | in/out    | APB, pready tied high  | staging_base @0x0, relocation_delta @0x8
//
// The front end takes a word whenever the command queue has room, keeps the
// running offset and queues a run command (up to two wait). The back end loads
// a run, then emits one target per cycle while results are taken; it loads the
// next run only after the last target of the current one is out.
// An empty bitmap only moves the offset and costs the back end nothing.
// Reset is synchronous, active high; it clears the offset, both registers,
// the queue and the result register. Either side may stall without limit.
module relr_relocation_decoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   // input item channel
   input  logic                            req_push,
   output logic                            req_full,
   input  relr_pkg::req_type               req_data,
   // result item channel
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output relr_pkg::rsp_type               rsp_data,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [relr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [relr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [relr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [relr_pkg::WORD_W-1:0] staging_base_ff;
   logic [relr_pkg::WORD_W-1:0] staging_base_in;
   logic [relr_pkg::WORD_W-1:0] relocation_delta_ff;
   logic [relr_pkg::WORD_W-1:0] relocation_delta_in;
   relr_pkg::csr_index_type     csr_index;
   logic                        csr_write;

   logic                        cmd_push;
   logic                        cmd_full;
   logic                        cmd_empty;
   logic                        cmd_pop;
   relr_pkg::cmd_type           cmd_in_data;
   relr_pkg::cmd_type           cmd_out_data;
   relr_pkg::back_stat_type     back_stat;

   // Register file: the index comes from the 8-byte slot bit of the address.
   always_comb begin
      csr_pready          = 1'b1;
      csr_index           = relr_pkg::csr_index_type'(csr_paddr[relr_pkg::CSR_IDX_BIT]);
      csr_write           = csr_psel && csr_penable && csr_pwrite && csr_pready;
      staging_base_in     = staging_base_ff;
      relocation_delta_in = relocation_delta_ff;
      csr_prdata          = '0;
      case (csr_index)
         relr_pkg::CSR_STAGING_BASE: begin
            csr_prdata = staging_base_ff;
            if (csr_write) begin
               staging_base_in = csr_pwdata;
            end
         end
         relr_pkg::CSR_RELOCATION_DELTA: begin
            csr_prdata = relocation_delta_ff;
            if (csr_write) begin
               relocation_delta_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         staging_base_ff     <= '0;
         relocation_delta_ff <= '0;
      end else begin
         staging_base_ff     <= staging_base_in;
         relocation_delta_ff <= relocation_delta_in;
      end
   end

   // Classify words and advance the running offset.
   relr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   // Decouple the two halves so each can stall on its own.
   relr_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   // Expand each run into patch targets.
   relr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_data         (cmd_out_data),
      .cmd_pop          (cmd_pop),
      .staging_base     (staging_base_ff),
      .relocation_delta (relocation_delta_ff),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .stat             (back_stat)
   );

`ifndef NO_ASSERTIONS
   // The front end never pushes into a full command queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");

   // Emitting the last target of a run leaves the back end idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (back_stat.emit && back_stat.last) |=> !back_stat.busy)
      else $error("back end still busy after last target");

   // A result only appears after the back end emitted it.
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> $past(back_stat.emit))
      else $error("result appeared without an emit");
`endif

endmodule

FILE: tb/relr_target_checker.sv
// Checker for the RELR decoder: tracks registers, predicts patch targets and compares them.
`timescale 1ns / 100ps

module relr_target_checker
   import relr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  req_type               req_data,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    targets_pending,
   output int                    targets_checked
);

   localparam int PRINT_LIMIT = 40;

   logic [WORD_W-1:0] staging_base_q;
   logic [WORD_W-1:0] add_value_q;
   logic [WORD_W-1:0] patch_ofs;
   rsp_type           expected_targets[$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("checker: %s", msg);
      end
      mismatch_count++;
   endtask

   task automatic predict_targets(input req_type item);
      rsp_type t;
      int      last_k;
      t.add_value = add_value_q;
      if (!item.relr_word[0]) begin
         patch_ofs = item.relr_word;
         t.target_address = staging_base_q + patch_ofs;
         t.last_of_run    = 1'b1;
         expected_targets.push_back(t);
         patch_ofs = patch_ofs + WORD_STEP;
      end else begin
         last_k = 0;
         for (int k = 1; k < 64; k++) begin
            if (item.relr_word[k]) begin
               last_k = k;
            end
         end
         for (int k = 1; k <= last_k; k++) begin
            if (item.relr_word[k]) begin
               t.target_address = staging_base_q + patch_ofs + WORD_W'(k - 1) * WORD_STEP;
               t.last_of_run    = (k == last_k);
               expected_targets.push_back(t);
            end
         end
         patch_ofs = patch_ofs + BITMAP_SPAN;
      end
      if (item.table_end) begin
         patch_ofs = '0;
      end
   endtask

   task automatic check_target(input rsp_type got);
      rsp_type want;
      if (expected_targets.size() == 0) begin
         report_mismatch($sformatf("unexpected target %h", got.target_address));
         return;
      end
      want = expected_targets.pop_front();
      targets_checked++;
      if (got.target_address !== want.target_address) begin
         report_mismatch($sformatf("target_address %h, expected %h",
                                   got.target_address, want.target_address));
      end
      if (got.add_value !== want.add_value) begin
         report_mismatch($sformatf("add_value %h, expected %h (target %h)",
                                   got.add_value, want.add_value, want.target_address));
      end
      if (got.last_of_run !== want.last_of_run) begin
         report_mismatch($sformatf("last_of_run %b, expected %b (target %h)",
                                   got.last_of_run, want.last_of_run, want.target_address));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         staging_base_q = '0;
         add_value_q    = '0;
         patch_ofs      = '0;
         expected_targets.delete();
         mismatch_count  = 0;
         targets_checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_IDX_BIT]))
               CSR_STAGING_BASE:     staging_base_q = csr_pwdata;
               CSR_RELOCATION_DELTA: add_value_q    = csr_pwdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predict_targets(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            check_target(rsp_data);
         end
      end
      targets_pending = expected_targets.size();
   end

endmodule

FILE: tb/tb.sv
// Top of the RELR decoder testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
   import relr_pkg::*;

   // Cycles with no accepted item before the run is declared hung. The slowest
   // legal stretch is the long receiver hold-off, well below this.
   localparam int IDLE_LIMIT     = 5000;
   // Receiver hold-off used to fill the block and back-pressure the input.
   localparam int HOLD_CYCLES    = 300;
   // Quiet cycles after the last target before touching the registers.
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 84;
   localparam int RANDOM_PHASES  = 4;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   req_type               req_data;
   logic                  rsp_empty;
   logic                  rsp_pop;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int targets_pending;
   int targets_checked;

   // Pacing knobs shared by the sender and receiver processes.
   bit sender_eager;
   bit rsp_eager;
   bit hold_rsp;

   int items_sent;
   int table_count;
   int reg_writes;
   int idle_cycles;

   relr_relocation_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   relr_target_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data        (req_data),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .targets_pending (targets_pending),
      .targets_checked (targets_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: restart the count on any accepted item in either direction.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: watchdog expired, %0d targets still pending", targets_pending);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver: pop with a random stall before each item, or none at all in
   // eager stretches. A hold request parks pop low for a long stretch so the
   // block backs up into its input queue.
   initial begin : receiver
      int stall;
      do @(negedge clock); while (reset);
      forever begin
         stall = rsp_eager ? 0 : $urandom_range(0, 5);
         if (hold_rsp) begin
            stall    = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         // hold pop high until an item is actually taken
         do @(posedge clock); while (rsp_empty !== 1'b0);
      end
   end

   // Offer one word after a random gap; push stays high across back-to-back
   // items so it is never lowered and raised at the same edge.
   task automatic send_item(input logic [WORD_W-1:0] word, input logic last_word);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push           <= 1'b1;
      req_data.relr_word <= word;
      req_data.table_end <= last_word;
      do @(posedge clock); while (req_full !== 1'b0);
      items_sent++;
   endtask

   // Drop push, wait for every predicted target, then let the pipe go quiet.
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (targets_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << CSR_IDX_BIT;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_writes++;
   endtask

   function automatic logic [WORD_W-1:0] pick_address();
      logic [WORD_W-1:0] w;
      w = {$urandom, $urandom};
      // now and then start close to the top so the offset wraps
      if ($urandom_range(0, 4) == 0) begin
         w = {52'hFFFF_FFFF_FFFF_F, w[11:0]};
      end
      return w & ~WORD_W'(1);
   endfunction

   function automatic logic [WORD_W-1:0] pick_bitmap();
      logic [WORD_W-1:0] w;
      int                sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
         // sparse map, the usual case
         w = WORD_W'(1);
         repeat ($urandom_range(1, 4)) w[$urandom_range(1, 63)] = 1'b1;
      end else if (sel < 16) begin
         w = {$urandom, $urandom} | WORD_W'(1);
      end else if (sel < 18) begin
         w = WORD_W'(1);
      end else begin
         w = '1;
      end
      return w;
   endfunction

   // One table: mostly an address word followed by bitmaps and an end mark,
   // with a few tables left open, led by a bitmap, or mixed with raw noise.
   task automatic send_table();
      int                len;
      bit                closed;
      logic [WORD_W-1:0] w;
      len    = $urandom_range(1, 6);
      closed = ($urandom_range(0, 9) != 0);
      sender_eager = ($urandom_range(0, 3) == 0);
      rsp_eager    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if (i == 0) begin
            w = ($urandom_range(0, 9) != 0) ? pick_address() : pick_bitmap();
         end else begin
            case ($urandom_range(0, 9))
               0:       w = pick_address();
               1:       w = {$urandom, $urandom};
               default: w = pick_bitmap();
            endcase
         end
         send_item(w, closed && (i == len - 1));
      end
      table_count++;
   endtask

   initial begin : stimulus
      int target;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;
      rsp_pop     = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      hold_rsp    = 1'b0;
      sender_eager = 1'b0;
      rsp_eager    = 1'b0;
      items_sent  = 0;
      table_count = 0;
      reg_writes  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, base at zero and the largest add value.
      write_reg(CSR_STAGING_BASE, '0);
      write_reg(CSR_RELOCATION_DELTA, '1);
      send_item(64'h0000_0000_0000_0005, 1'b0);   // bitmap before any address
      send_item(64'h0000_0000_0000_0001, 1'b0);   // empty bitmap
      send_item(64'h0000_0000_0000_0000, 1'b0);   // address zero
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);   // every bit of the map
      send_item(64'h8000_0000_0000_0001, 1'b0);   // top slot only
      send_item(64'h0000_0000_0000_0003, 1'b0);   // first slot only
      send_item(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);   // address near the top
      send_item(64'h0000_0000_0000_000F, 1'b0);   // map wraps through zero
      send_item(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);   // largest address, end of table
      send_item(64'h0000_0000_0000_0007, 1'b0);   // map right after a table end
      send_item(64'h0000_0000_0000_0001, 1'b1);   // empty map closing a table
      send_item(64'h5555_5555_5555_5554, 1'b0);
      send_item(64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
      send_item(64'h5555_5555_5555_5555, 1'b1);   // map closing a table
      settle();

      // Directed, base at the top so every target sum wraps; no idling.
      write_reg(CSR_STAGING_BASE, '1);
      write_reg(CSR_RELOCATION_DELTA, '0);
      sender_eager = 1'b1;
      rsp_eager    = 1'b1;
      send_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(64'h0000_0000_0000_0008, 1'b0);
      send_item(64'h8000_0000_0000_0003, 1'b1);
      send_item(64'h0000_0000_0000_0002, 1'b0);
      settle();

      // Random tables under fresh register values per phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_reg(CSR_STAGING_BASE, {$urandom, $urandom});
         write_reg(CSR_RELOCATION_DELTA, {$urandom, $urandom});
         target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         if (phase == 1) begin
            // park the receiver and keep pushing full maps until input stalls
            hold_rsp     = 1'b1;
            sender_eager = 1'b1;
            repeat (8) send_item('1, 1'b0);
            sender_eager = 1'b0;
         end
         while (items_sent < target) begin
            send_table();
         end
         // wait out every target before the next register change
         settle();
      end

      repeat (20) @(negedge clock);
      $display("tb: %0d words in %0d random tables plus directed cases, %0d register writes",
               items_sent, table_count, reg_writes);
      $display("tb: %0d patch targets compared, %0d mismatches, %0d left over",
               targets_checked, mismatch_count, targets_pending);
      if (mismatch_count == 0 && targets_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
